// ===== rtl/core/ypg_pkg.sv =====
// shared constants and coefficient helpers for the yuv grayscale block
package ypg_pkg;

    localparam int       CoefFracBitsDefault = 16;
    localparam longint   Micro               = 1000000;

    // coefficients in millionths
    localparam longint   KrvMicro = 1370705;
    localparam longint   KgvMicro = 698001;
    localparam longint   KguMicro = 337633;
    localparam longint   KbuMicro = 1732446;

    localparam logic [7:0] ChromaOffset  = 8'd128;
    localparam logic [7:0] ChannelMax    = 8'd255;

    // floor(x / 3) as (x * 683) >> 11, exact for x up to 765
    localparam logic [9:0] Div3Mul   = 10'd683;
    localparam int         Div3Shift = 11;

    typedef enum logic [0:0]
    {
        GRAY_AVG = 1'b0,
        GRAY_MIN = 1'b1
    } gray_mode_t;

    // scale by 2^frac_bits and round half up
    function automatic longint rounded_coef(input longint micro_val, input int frac_bits);
        return ((micro_val <<< frac_bits) + Micro / 2) / Micro;
    endfunction

endpackage

// ===== rtl/core/yuv_pixel_grayscale_top.sv =====
// yuv pixel to grayscale converter, top level
//
// usage:
//   s_axis carries one yuv pixel per beat (y, u, v bytes); m_axis carries the
//   gray pixel with luma set to the gray value and both chroma bytes at 128.
//   cfg_valid/cfg_data write the gray mode bit (0 average, 1 minimum); cfg_ready
//   is always high. write it only while no pixel is in flight.
// pipeline and throughput:
//   pixels pass the input register, then the output register that feeds m_axis.
//   one pixel per cycle is sustained: the input register feeds a single pass of
//   fixed-point color conversion, clamp and gray selection into the output
//   register, and both stages move together whenever the output is free or
//   being taken.
// reset:
//   rst_n clears both stage valid flags and sets the mode to average.
// stall:
//   while m_axis_tready is low the result holds; one further pixel is still
//   accepted into the input register, after which s_axis_tready drops until
//   the output drains.
module yuv_pixel_grayscale_top #(
    parameter int COEF_FRAC_BITS = ypg_pkg::CoefFracBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // luma_in, blue_diff_in, red_diff_in

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // luma_out, blue_diff_out, red_diff_out

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [0:0]  cfg_data        // gray_mode
);

    localparam int CW = COEF_FRAC_BITS + 2;
    localparam int SW = COEF_FRAC_BITS + 10;

    localparam longint KrvL = ypg_pkg::rounded_coef(ypg_pkg::KrvMicro, COEF_FRAC_BITS);
    localparam longint KgvL = ypg_pkg::rounded_coef(ypg_pkg::KgvMicro, COEF_FRAC_BITS);
    localparam longint KguL = ypg_pkg::rounded_coef(ypg_pkg::KguMicro, COEF_FRAC_BITS);
    localparam longint KbuL = ypg_pkg::rounded_coef(ypg_pkg::KbuMicro, COEF_FRAC_BITS);

    localparam logic signed [CW-1:0] KRV = KrvL[CW-1:0];
    localparam logic signed [CW-1:0] KGV = KgvL[CW-1:0];
    localparam logic signed [CW-1:0] KGU = KguL[CW-1:0];
    localparam logic signed [CW-1:0] KBU = KbuL[CW-1:0];

    ypg_pkg::gray_mode_t mode_reg;

    logic       in_valid_reg;
    logic [7:0] y_reg;
    logic [7:0] u_reg;
    logic [7:0] v_reg;

    logic       out_valid_reg;
    logic [7:0] gray_reg;
    logic [7:0] gray_next;

    logic       advance;

    logic signed [8:0]    du;
    logic signed [8:0]    dv;
    logic signed [SW-1:0] base;
    logic signed [SW-1:0] r_sum;
    logic signed [SW-1:0] g_sum;
    logic signed [SW-1:0] b_sum;
    logic [7:0]           r_val;
    logic [7:0]           g_val;
    logic [7:0]           b_val;
    logic [9:0]           rgb_total;
    logic [19:0]          div_prod;
    logic [7:0]           min_rg;

    function automatic logic [7:0] chan_clamp(input logic signed [SW-1:0] sum);
        logic [8:0] whole;
        whole = sum[SW-2:COEF_FRAC_BITS];
        if (sum[SW-1])
            return 8'd0;
        else if (whole[8])
            return ypg_pkg::ChannelMax;
        else
            return whole[7:0];
    endfunction

    assign cfg_ready     = 1'b1;
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= ypg_pkg::GRAY_AVG;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= ypg_pkg::gray_mode_t'(cfg_data);
        end
    end

    // input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            y_reg <= s_axis_tdata[7:0];
            u_reg <= s_axis_tdata[15:8];
            v_reg <= s_axis_tdata[23:16];
        end
    end

    // color conversion and gray selection
    always_comb
    begin
        du    = $signed({1'b0, u_reg}) - $signed({1'b0, ypg_pkg::ChromaOffset});
        dv    = $signed({1'b0, v_reg}) - $signed({1'b0, ypg_pkg::ChromaOffset});
        base  = $signed({{(SW-8){1'b0}}, y_reg}) <<< COEF_FRAC_BITS;
        r_sum = base + SW'(KRV) * SW'(dv);
        g_sum = base - SW'(KGV) * SW'(dv) - SW'(KGU) * SW'(du);
        b_sum = base + SW'(KBU) * SW'(du);
        r_val = chan_clamp(r_sum);
        g_val = chan_clamp(g_sum);
        b_val = chan_clamp(b_sum);

        rgb_total = {2'b00, r_val} + {2'b00, g_val} + {2'b00, b_val};
        div_prod  = {10'd0, rgb_total} * {10'd0, ypg_pkg::Div3Mul};

        min_rg = (g_val < r_val) ? g_val : r_val;

        case (mode_reg)
            ypg_pkg::GRAY_MIN: gray_next = (b_val < min_rg) ? b_val : min_rg;
            default:           gray_next = div_prod[ypg_pkg::Div3Shift +: 8];
        endcase
    end

    // output stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
        begin
            gray_reg <= gray_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {ypg_pkg::ChromaOffset, ypg_pkg::ChromaOffset, gray_reg};

endmodule

// ===== rtl/core/ypg_checker.sv =====
// port-level checks for the yuv grayscale block and their bind
module ypg_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    // stalled result beat stays valid
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    // chroma is always neutral
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:8] == {8'd128, 8'd128})
        else $error("output chroma not neutral");

    // an accepted pixel shows up at the output
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
        else $error("accepted pixel did not reach output");

    // no result without an accepted pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("output beat without input beat");

endmodule

bind yuv_pixel_grayscale_top ypg_checker u_ypg_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== tb/gray_pixel_checker.sv =====
// checker for the yuv grayscale block: predicts each gray pixel and compares output beats
`timescale 1ns / 100ps

module gray_pixel_checker #(
    parameter int FRAC_BITS = ypg_pkg::CoefFracBitsDefault
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // luma_in, blue_diff_in, red_diff_in

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // luma_out, blue_diff_out, red_diff_out

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [0:0]  cfg_data,       // gray_mode

    output int          fail_count,
    output int          in_flight
);

    localparam longint Half = 500000;
    localparam longint Mega = 1000000;
    localparam longint KRed   = ((ypg_pkg::KrvMicro <<< FRAC_BITS) + Half) / Mega;
    localparam longint KGreenV = ((ypg_pkg::KgvMicro <<< FRAC_BITS) + Half) / Mega;
    localparam longint KGreenU = ((ypg_pkg::KguMicro <<< FRAC_BITS) + Half) / Mega;
    localparam longint KBlue  = ((ypg_pkg::KbuMicro <<< FRAC_BITS) + Half) / Mega;

    typedef struct packed {
        logic [7:0] red_diff;
        logic [7:0] blue_diff;
        logic [7:0] luma;
    } yuv_pixel_t;

    ypg_pkg::gray_mode_t  mode;
    yuv_pixel_t  gray_pixels_due[$];
    int          mismatches;

    function automatic logic [7:0] clamp_channel(input longint sum);
        longint whole;
        if (sum < 0)
            return 8'd0;
        whole = sum >>> FRAC_BITS;
        if (whole > 255)
            return 8'd255;
        return whole[7:0];
    endfunction

    function automatic yuv_pixel_t gray_of_pixel(input yuv_pixel_t px,
                                                 input ypg_pkg::gray_mode_t m);
        longint     base;
        longint     du;
        longint     dv;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [9:0] total;
        yuv_pixel_t res;
        base = longint'(px.luma) <<< FRAC_BITS;
        du = longint'(px.blue_diff) - 128;
        dv = longint'(px.red_diff) - 128;
        r = clamp_channel(base + KRed * dv);
        g = clamp_channel(base - KGreenV * dv - KGreenU * du);
        b = clamp_channel(base + KBlue * du);
        if (m == ypg_pkg::GRAY_MIN)
        begin
            res.luma = r;
            if (g < res.luma)
                res.luma = g;
            if (b < res.luma)
                res.luma = b;
        end
        else
        begin
            total = {2'b00, r} + {2'b00, g} + {2'b00, b};
            total = total / 10'd3;
            res.luma = total[7:0];
        end
        res.blue_diff = ypg_pkg::ChromaOffset;
        res.red_diff = ypg_pkg::ChromaOffset;
        return res;
    endfunction

    task automatic note_failure(input string what, input yuv_pixel_t exp_px,
                                input yuv_pixel_t got_px);
        mismatches++;
        fail_count <= mismatches;
        if (mismatches <= 10)
            $display("%0t: %s: expected y=%0d u=%0d v=%0d, got y=%0d u=%0d v=%0d",
                     $realtime, what, exp_px.luma, exp_px.blue_diff, exp_px.red_diff,
                     got_px.luma, got_px.blue_diff, got_px.red_diff);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        yuv_pixel_t exp_px;
        yuv_pixel_t got_px;
        if (!rst_n)
        begin
            mode <= ypg_pkg::GRAY_AVG;
            gray_pixels_due.delete();
            in_flight <= 0;
            fail_count <= 0;
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_px = m_axis_tdata;
                if (gray_pixels_due.size() == 0)
                    note_failure("unexpected output beat", '0, got_px);
                else
                begin
                    exp_px = gray_pixels_due.pop_front();
                    if (got_px.luma != exp_px.luma || got_px.blue_diff != exp_px.blue_diff
                        || got_px.red_diff != exp_px.red_diff)
                        note_failure("output beat mismatch", exp_px, got_px);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                gray_pixels_due.push_back(gray_of_pixel(s_axis_tdata, mode));
            if (cfg_valid && cfg_ready)
                mode <= ypg_pkg::gray_mode_t'(cfg_data);
            in_flight <= gray_pixels_due.size();
        end
    end

endmodule

// ===== tb/tb_yuv_pixel_grayscale_top.sv =====
// testbench top for the yuv grayscale block: clock, reset, stimulus and verdict
`timescale 1ns / 100ps

module tb_yuv_pixel_grayscale_top;

    localparam int FracBits      = ypg_pkg::CoefFracBitsDefault;
    localparam int RxStallCycles = 300;
    localparam int RandomPerPhase = 320;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [0:0]  cfg_data = '0;

    int          fail_count;
    int          in_flight;
    bit          tx_idle_on;
    bit          rx_idle_on;
    bit          rx_stall_req;
    bit          rx_stall_done;

    always #5 clk = ~clk;

    yuv_pixel_grayscale_top #(
        .COEF_FRAC_BITS(FracBits)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    gray_pixel_checker #(
        .FRAC_BITS(FracBits)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .in_flight    (in_flight)
    );

    function automatic logic [23:0] yuv(input logic [7:0] y, input logic [7:0] u,
                                        input logic [7:0] v);
        return {v, u, y};
    endfunction

    function automatic logic [7:0] random_byte();
        logic [7:0] corner[7];
        corner = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
        if ($urandom_range(0, 5) == 0)
            return corner[$urandom_range(0, 6)];
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic send_pixel(input logic [23:0] px);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 16) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= px;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // mode changes only with the pipe empty
    task automatic set_gray_mode(input ypg_pkg::gray_mode_t m);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (in_flight == 0);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_corner_pixels();
        logic [23:0] corners[12];
        corners = '{yuv(8'd0, 8'd0, 8'd0), yuv(8'd255, 8'd255, 8'd255),
                    yuv(8'd0, 8'd128, 8'd128), yuv(8'd255, 8'd128, 8'd128),
                    yuv(8'd128, 8'd0, 8'd0), yuv(8'd128, 8'd255, 8'd255),
                    yuv(8'd0, 8'd255, 8'd0), yuv(8'd255, 8'd0, 8'd255),
                    yuv(8'd128, 8'd0, 8'd255), yuv(8'd128, 8'd255, 8'd0),
                    yuv(8'd16, 8'd128, 8'd128), yuv(8'd235, 8'd129, 8'd127)};
        foreach (corners[i])
            send_pixel(corners[i]);
    endtask

    task automatic send_random_pixels(input int count);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            send_pixel(yuv(random_byte(), random_byte(), random_byte()));
        end
    endtask

    // receiver: random hold-offs, plus one long stall on request
    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            if (rx_stall_req && !rx_stall_done)
            begin
                rx_stall_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (RxStallCycles) @(posedge clk);
            end
            gap = rx_idle_on ? $urandom_range(0, 16) : 0;
            if (gap > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid) @(posedge clk);
        end
    end

    initial
    begin
        #3000000;
        $display("yuv_pixel_grayscale_top test failed");
        $finish;
    end

    initial
    begin
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_corner_pixels();
        set_gray_mode(ypg_pkg::GRAY_MIN);
        send_corner_pixels();

        set_gray_mode(ypg_pkg::GRAY_AVG);
        send_random_pixels(RandomPerPhase);

        // long output stall with the input kept busy
        tx_idle_on = 1'b0;
        rx_stall_req = 1'b1;
        for (int i = 0; i < 20; i++)
            send_pixel(yuv(random_byte(), random_byte(), random_byte()));

        set_gray_mode(ypg_pkg::GRAY_MIN);
        send_random_pixels(RandomPerPhase);
        set_gray_mode(ypg_pkg::GRAY_AVG);
        send_random_pixels(RandomPerPhase);
        set_gray_mode(ypg_pkg::GRAY_MIN);
        send_random_pixels(RandomPerPhase);

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        wait (in_flight == 0);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && in_flight == 0)
            $display("yuv_pixel_grayscale_top test passed");
        else
            $display("yuv_pixel_grayscale_top test failed");
        $finish;
    end

endmodule
